// ----- hw/rtl/llars_pkg.sv -----
// Shared types, constants and the per-row rule function for the row step block.
package llars_pkg;

  localparam int ROW_BITS      = 64;
  localparam int MAX_WIDTH_DEF = 64;
  localparam int WIDTH_BITS    = 7;
  localparam int MASK_BITS     = 8;
  localparam int ADDR_BITS     = 4;
  localparam int DATA_BITS     = 32;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_BIRTH    = 2'd0;
  localparam logic [1:0] REG_SURVIVAL = 2'd1;
  localparam logic [1:0] REG_WIDTH    = 2'd2;

  localparam logic [MASK_BITS-1:0]  BIRTH_RESET    = 8'd4;
  localparam logic [MASK_BITS-1:0]  SURVIVAL_RESET = 8'd6;
  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET    = 7'd64;

  typedef logic [ROW_BITS-1:0] row_t;

  // bit c set for every column below the effective width
  function automatic row_t active_mask(input logic [WIDTH_BITS-1:0] w);
    row_t am;
    am = '0;
    for (int c = 0; c < ROW_BITS; c++) begin
      am[c] = (WIDTH_BITS'(c) < w);
    end
    return am;
  endfunction

  // next generation of the middle row; out-of-grid neighbors are dead
  function automatic row_t next_row(input row_t up, input row_t mid, input row_t down,
                                    input row_t am, input logic [MASK_BITS-1:0] bmask,
                                    input logic [MASK_BITS-1:0] smask);
    logic [ROW_BITS+1:0]  u;
    logic [ROW_BITS+1:0]  m;
    logic [ROW_BITS+1:0]  d;
    logic [3:0]           k;
    logic [MASK_BITS-1:0] rule;
    row_t                 res;
    u = {1'b0, up & am, 1'b0};
    m = {1'b0, mid & am, 1'b0};
    d = {1'b0, down & am, 1'b0};
    res = '0;
    for (int c = 0; c < ROW_BITS; c++) begin
      k = 4'(u[c]) + 4'(u[c+1]) + 4'(u[c+2]) + 4'(m[c]) + 4'(m[c+2])
        + 4'(d[c]) + 4'(d[c+1]) + 4'(d[c+2]);
      rule = m[c+1] ? smask : bmask;
      res[c] = (k != 4'd0) && rule[3'(k - 4'd1)];
    end
    return res & am;
  endfunction

endpackage

// ----- hw/rtl/life_like_automaton_row_step.sv -----
// Top level: streaming one-generation step of a life-like automaton, one row per transfer.
//
// Rows of the current generation come in one per transfer (bit c = column c) and the
// next-generation rows go out one row behind: the first row of a grid produces nothing,
// every later row produces one row, and the row flagged last_row also produces the closing
// row with final_row set. The grid does not wrap; cells outside it and columns at or above
// row_width (saturated to MAX_WIDTH) are dead, and next_cells is zero there. A cell with k
// live neighbors (1..8) is born when birth_mask[k-1] is set and survives when
// survival_mask[k-1] is set; k = 0 never gives a live cell. Throughput is one row per
// cycle while the result queue has two free slots: an input register feeds the
// count-and-rule logic, whose results go into a four-entry result queue. A last row
// pushes two results at once, which the silent first row of each grid makes up for, so
// the input never stalls while the output drains at full rate; it stalls whenever the
// queue lacks two free slots.
// Registers (APB, 32-bit, pready tied high): 0x0 birth_mask, 0x4 survival_mask,
// 0x8 row_width. Write them only while no row is in flight.
module life_like_automaton_row_step #(
  parameter int MAX_WIDTH = llars_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [llars_pkg::ADDR_BITS-1:0] paddr,
  input  logic [llars_pkg::DATA_BITS-1:0] pwdata,
  output logic [llars_pkg::DATA_BITS-1:0] prdata,
  output logic                           pready,
  // input rows
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [llars_pkg::ROW_BITS-1:0] row_cells,
  input  logic                           last_row,
  // result rows
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [llars_pkg::ROW_BITS-1:0] next_cells,
  output logic                           final_row
);
  import llars_pkg::*;

  localparam logic [WIDTH_BITS-1:0] MAX_W = WIDTH_BITS'(MAX_WIDTH);
  localparam logic [QPTR_BITS:0]    Q_LIMIT = (QPTR_BITS+1)'(QUEUE_DEPTH - 2);

  // configuration registers
  logic [MASK_BITS-1:0]  birth_mask;
  logic [MASK_BITS-1:0]  survival_mask;
  logic [WIDTH_BITS-1:0] row_width;

  // input stage
  logic s1_valid;
  row_t s1_row;
  logic s1_last;

  // grid state
  row_t row_above;
  row_t row_center;
  logic rows_seen;

  // result queue
  row_t             q_cells [QUEUE_DEPTH];
  logic             q_final [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] q_head;
  logic [QPTR_BITS-1:0] q_tail;
  logic [QPTR_BITS:0]   q_count;

  logic                  cfg_wr;
  logic                  in_take;
  logic                  s1_go;
  logic                  q_pop;
  logic [1:0]            push_n;
  logic [WIDTH_BITS-1:0] w_eff;
  row_t                  am;
  row_t                  cur_row;
  row_t                  res_mid;
  row_t                  res_end;
  row_t                  push0_cells;
  logic                  push0_final;
  logic [QPTR_BITS-1:0]  q_tail_1;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      birth_mask    <= BIRTH_RESET;
      survival_mask <= SURVIVAL_RESET;
      row_width     <= WIDTH_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_BIRTH:    birth_mask    <= pwdata[MASK_BITS-1:0];
        REG_SURVIVAL: survival_mask <= pwdata[MASK_BITS-1:0];
        REG_WIDTH:    row_width     <= pwdata[WIDTH_BITS-1:0];
        default: ;  // unmapped: ignored
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_BIRTH:    prdata = DATA_BITS'(birth_mask);
      REG_SURVIVAL: prdata = DATA_BITS'(survival_mask);
      REG_WIDTH:    prdata = DATA_BITS'(row_width);
      default:      prdata = '0;
    endcase
  end

  // ---------------- input stage ----------------
  // the held row moves on only when the queue can take both possible results
  assign s1_go    = s1_valid && (q_count <= Q_LIMIT);
  assign in_stall = s1_valid && !s1_go;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_row  <= row_cells;
      s1_last <= last_row;
    end
  end

  // ---------------- row computation ----------------
  assign w_eff   = (row_width > MAX_W) ? MAX_W : row_width;
  assign am      = active_mask(w_eff);
  assign cur_row = s1_row & am;

  // row_above is zero whenever no row is held, so no extra gating is needed here
  assign res_mid = next_row(row_above, row_center, cur_row, am, birth_mask, survival_mask);
  // closing row: the incoming row is the middle one, nothing below it
  assign res_end = next_row(rows_seen ? row_center : '0, cur_row, '0, am,
                            birth_mask, survival_mask);

  assign push_n      = s1_go ? (2'(rows_seen) + 2'(s1_last)) : 2'd0;
  assign push0_cells = rows_seen ? res_mid : res_end;
  assign push0_final = !rows_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_seen <= 1'b0;
    end else if (s1_go) begin
      rows_seen <= !s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_above  <= '0;
      row_center <= '0;
    end else if (s1_go) begin
      if (s1_last) begin
        row_above  <= '0;
        row_center <= '0;
      end else begin
        row_above  <= rows_seen ? row_center : '0;
        row_center <= cur_row;
      end
    end
  end

  // ---------------- result queue ----------------
  assign q_pop    = out_valid && !out_stall;
  assign q_tail_1 = q_tail + 1'b1;

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_cells[q_tail] <= push0_cells;
      q_final[q_tail] <= push0_final;
    end
    if (push_n == 2'd2) begin
      q_cells[q_tail_1] <= res_end;
      q_final[q_tail_1] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_head  <= '0;
      q_tail  <= '0;
      q_count <= '0;
    end else begin
      q_tail  <= q_tail + QPTR_BITS'(push_n);
      q_count <= q_count + (QPTR_BITS+1)'(push_n) - (QPTR_BITS+1)'(q_pop);
      if (q_pop) begin
        q_head <= q_head + 1'b1;
      end
    end
  end

  assign out_valid  = (q_count != '0);
  assign next_cells = q_cells[q_head];
  assign final_row  = q_final[q_head];

endmodule

// ----- verif/tb_life_like_automaton_row_step.sv -----
// Self-checking bench for the streaming life-like row step: directed grids, then random grids.
module tb_life_like_automaton_row_step;
  timeunit 1ns;
  timeprecision 1ps;

  import llars_pkg::*;

  // Quiet-cycle budget. The slowest correct stretch is the long receiver hold
  // (LONG_HOLD) in the pressure phase; everything else is much shorter.
  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 300;
  localparam int CFG_SETTLE  = 8;   // covers the input register and result queue, plus margin
  localparam int END_SETTLE  = 20;

  typedef struct packed {
    row_t cells;
    logic fin;
  } out_row_t;

  // Tracks rule registers and the two held rows, predicts each next-generation
  // row as input transfers are accepted, and checks result transfers in order.
  class generation_checker;
    logic [MASK_BITS-1:0]  birth_rule;
    logic [MASK_BITS-1:0]  survive_rule;
    logic [WIDTH_BITS-1:0] width_reg;
    row_t                  held_above;
    row_t                  held_mid;
    bit                    row_held;
    out_row_t              pending_rows[$];
    int                    errors;

    function new();
      birth_rule   = 8'd4;
      survive_rule = 8'd6;
      width_reg    = 7'd64;
      held_above   = '0;
      held_mid     = '0;
      row_held     = 0;
      errors       = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [DATA_BITS-1:0] value);
      case (idx)
        REG_BIRTH:    birth_rule   = value[MASK_BITS-1:0];
        REG_SURVIVAL: survive_rule = value[MASK_BITS-1:0];
        REG_WIDTH:    width_reg    = value[WIDTH_BITS-1:0];
        default: ;
      endcase
    endfunction

    // columns below the effective width, width saturating at 64
    function row_t live_columns();
      if (width_reg >= 7'd64) return '1;
      return (row_t'(1) << width_reg) - row_t'(1);
    endfunction

    function row_t evolve(row_t up, row_t mid, row_t down);
      row_t                 am;
      row_t                 nxt;
      int                   k;
      logic [MASK_BITS-1:0] rule;
      am   = live_columns();
      up   = up & am;
      mid  = mid & am;
      down = down & am;
      nxt  = '0;
      for (int c = 0; c < ROW_BITS; c++) begin
        k = 0;
        for (int dc = -1; dc <= 1; dc++) begin
          if (c + dc >= 0 && c + dc < ROW_BITS) begin
            k += up[c+dc] + down[c+dc];
            if (dc != 0) k += mid[c+dc];
          end
        end
        rule = mid[c] ? survive_rule : birth_rule;
        nxt[c] = (k >= 1) && rule[k-1];
      end
      return nxt & am;
    endfunction

    function void accept_row(row_t cells, logic is_last);
      row_t row;
      row = cells & live_columns();
      if (!row_held) begin
        held_above = '0;
        held_mid   = row;
      end else begin
        pending_rows.push_back('{evolve(held_above, held_mid, row), 1'b0});
        held_above = held_mid;
        held_mid   = row;
      end
      if (is_last) begin
        // closing row: nothing below it
        pending_rows.push_back('{evolve(held_above, held_mid, '0), 1'b1});
        held_above = '0;
        held_mid   = '0;
        row_held   = 0;
      end else begin
        row_held = 1;
      end
    endfunction

    function void check_row(row_t cells, logic fin);
      out_row_t want;
      if (pending_rows.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: next_cells=%h final_row=%0b",
                 $time, cells, fin);
        return;
      end
      want = pending_rows.pop_front();
      if (cells !== want.cells) begin
        errors++;
        $display("%0t: next_cells expected %h actual %h", $time, want.cells, cells);
      end
      if (fin !== want.fin) begin
        errors++;
        $display("%0t: final_row expected %0b actual %0b", $time, want.fin, fin);
      end
    endfunction

    function int pending();
      return pending_rows.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_BITS-1:0]  paddr;
  logic [DATA_BITS-1:0]  pwdata;
  logic [DATA_BITS-1:0]  prdata;
  logic                  pready;
  logic                  in_valid;
  logic                  in_stall;
  row_t                  row_cells;
  logic                  last_row;
  logic                  out_valid;
  logic                  out_stall;
  row_t                  next_cells;
  logic                  final_row;

  generation_checker chk = new();

  // Idle control shared between the stimulus and the result-side stall process.
  int send_idle_max = 15;
  int recv_idle_max = 15;
  bit hold_off_req  = 0;
  int quiet_cycles  = 0;

  int extreme_widths[6] = '{0, 1, 63, 64, 65, 127};

  life_like_automaton_row_step dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .row_cells  (row_cells),
    .last_row   (last_row),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .next_cells (next_cells),
    .final_row  (final_row)
  );

  always #5 clk = ~clk;

  // At least half the draws are zero so back-to-back transfers stay common.
  function automatic int draw_wait(int max_wait);
    if (max_wait == 0) return 0;
    return $urandom_range(0, 1) ? 0 : $urandom_range(0, max_wait);
  endfunction

  // Mix of densities: noise, sparse, dense, empty, full and a lone cell.
  function automatic row_t random_row();
    row_t a;
    row_t b;
    row_t c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0, 1, 2: return a;
      3:       return a & b & c;
      4:       return a | b;
      5:       return '0;
      6:       return '1;
      default: return row_t'(1) << $urandom_range(0, ROW_BITS - 1);
    endcase
  endfunction

  function automatic logic [MASK_BITS-1:0] pick_mask();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return MASK_BITS'($urandom);
  endfunction

  // APB write: setup cycle, then access; the register takes the write at the
  // edge where psel, penable, pwrite and pready are all high.
  task automatic write_reg(logic [1:0] idx, logic [DATA_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_BITS'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    chk.set_reg(idx, value);
    @(posedge clk);
  endtask

  // Drop valid and hold until every predicted row has come back.
  task automatic drain_inputs(int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (chk.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Rules only change between grids with the pipeline empty.
  task automatic configure(logic [MASK_BITS-1:0] b, logic [MASK_BITS-1:0] s,
                           logic [WIDTH_BITS-1:0] w);
    drain_inputs(CFG_SETTLE);
    write_reg(REG_BIRTH, DATA_BITS'(b));
    write_reg(REG_SURVIVAL, DATA_BITS'(s));
    write_reg(REG_WIDTH, DATA_BITS'(w));
  endtask

  // One input transfer. Valid stays up into the next row when no gap is drawn,
  // so it is never lowered and raised in the same step.
  task automatic send_row(row_t cells, logic is_last);
    int gap;
    gap = draw_wait(send_idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    row_cells <= cells;
    last_row  <= is_last;
    do @(posedge clk); while (in_stall);
    chk.accept_row(cells, is_last);
  endtask

  // Whole grids of random height, mostly short; now and then the sender stops
  // mid-grid until the block has caught up, with a row still held inside.
  task automatic run_random_grids(int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        send_row(random_row(), i == len - 1);
        if (i != len - 1 && $urandom_range(0, 59) == 0) drain_inputs(0);
      end
      sent += len;
    end
  endtask

  // Result side: draw a stall per result; a pending hold-off request turns the
  // next draw into one long stretch so the result queue fills and the input stalls.
  initial begin
    int hold;
    forever begin
      if (hold_off_req) begin
        hold = LONG_HOLD;
        hold_off_req = 0;
      end else begin
        hold = draw_wait(recv_idle_max);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Result transfers are checked with the values seen at the edge.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall) chk.check_row(next_cells, final_row);
  end

  // Watchdog: too long without any transfer on either side ends the run.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("tb_life_like_automaton_row_step: done, errors");
      $finish;
    end
  end

  initial begin
    rst       <= 1'b1;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    in_valid  <= 1'b0;
    row_cells <= '0;
    last_row  <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // --- directed grids ---
    // classic B3/S23 at full width: single-row grid, full and striped rows,
    // edge columns, and a small glider shape
    configure(8'h04, 8'h06, 7'd64);
    send_row('1, 1'b1);
    send_row('0, 1'b0);
    send_row('1, 1'b0);
    send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    send_row(64'h5555_5555_5555_5555, 1'b0);
    send_row(64'h8000_0000_0000_0001, 1'b0);
    send_row('1, 1'b1);
    send_row(64'h2, 1'b0);
    send_row(64'h4, 1'b0);
    send_row(64'h7, 1'b1);

    // zero width: every column inactive, every result row empty
    configure(8'hFF, 8'h00, 7'd0);
    send_row('1, 1'b0);
    send_row('1, 1'b1);

    // width above the maximum saturates; every live cell with a live neighbor survives
    configure(8'h00, 8'hFF, 7'd127);
    send_row('1, 1'b0);
    send_row('1, 1'b0);
    send_row('1, 1'b1);

    // only a full neighborhood of eight keeps a cell
    configure(8'h80, 8'h80, 7'd65);
    send_row('1, 1'b0);
    send_row('1, 1'b0);
    send_row('1, 1'b1);

    // one active column: input bits above it must be ignored
    configure(8'h01, 8'h01, 7'd1);
    send_row('1, 1'b0);
    send_row(64'h1, 1'b1);

    // top column just outside the width
    configure(8'hAA, 8'h55, 7'd63);
    send_row('1, 1'b0);
    send_row(64'h8000_0000_0000_0000, 1'b1);

    // --- random grids ---
    // phase 2 is the pressure phase: sender never idles while the receiver
    // holds off; phase 5 runs with no idling on either side
    for (int p = 0; p < 8; p++) begin
      configure(pick_mask(), pick_mask(),
                ($urandom_range(0, 2) == 0) ? WIDTH_BITS'(extreme_widths[$urandom_range(0, 5)])
                                            : WIDTH_BITS'($urandom_range(1, 64)));
      send_idle_max = (p == 2 || p == 5) ? 0 : 15;
      recv_idle_max = (p == 5) ? 0 : 15;
      if (p == 2) hold_off_req = 1;
      run_random_grids(135);
    end

    drain_inputs(END_SETTLE);
    if (chk.errors == 0) begin
      $display("tb_life_like_automaton_row_step: done, clean");
    end else begin
      $display("tb_life_like_automaton_row_step: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/llars_pkg.sv
hw/rtl/life_like_automaton_row_step.sv
verif/tb_life_like_automaton_row_step.sv
